[rtl/scw_pkg.sv]
`default_nettype none
package scw_pkg;

	localparam int unsigned WAIT_SLOTS_DEF = 16;
	localparam int unsigned COUNT_W        = 32;
	localparam int unsigned FIBER_W        = 16;

	// request codes
	typedef enum logic [1:0] {
		REQ_INC  = 2'd0,
		REQ_DEC  = 2'd1,
		REQ_WAIT = 2'd2,
		REQ_READ = 2'd3
	} req_type_t;

	// result kinds
	typedef enum logic [2:0] {
		KIND_OLD      = 3'd0,
		KIND_RELEASED = 3'd1,
		KIND_WAITING  = 3'd2,
		KIND_READY    = 3'd3,
		KIND_FULL     = 3'd4,
		KIND_READ     = 3'd5
	} result_kind_t;

	// one wait slot as held in the slot memory
	typedef struct packed {
		logic [FIBER_W-1:0] fiber;
		logic [COUNT_W-1:0] target;
	} slot_entry_t;

	// one result beat
	typedef struct packed {
		result_kind_t       kind;
		logic [COUNT_W-1:0] value;
		logic [FIBER_W-1:0] fiber;
		logic               last;
	} beat_t;

endpackage
`default_nettype wire

[rtl/sync_counter_with_wait_slots.sv]
// an increment/decrement reads the slot memory one slot at a time and then loads the
// closing beat into the output register; add-waiter and read load only the closing beat,
// and output stalls hold both the scan and the closing beat
// throughput: one request at a time, one slot per cycle in the scan unless a release waits
// on a stalled output; the next request is taken only once the closing beat is loaded
// reset (arst_n low): count 0, every slot free; slot memory contents are not cleared
`default_nettype none
module sync_counter_with_wait_slots #(
	parameter int unsigned WAIT_SLOTS = scw_pkg::WAIT_SLOTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration: initial_count
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data,
	// request channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  req_type,
	input  wire logic [31:0] amount,
	input  wire logic [15:0] fiber_id,
	input  wire logic [31:0] target_value,
	// result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       result_kind,
	output logic [31:0]      count_value,
	output logic [15:0]      released_fiber,
	output logic             last_of_run
);

	localparam int unsigned IDX_W = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_ACK  = 3'b100
	} state_t;

	state_t                      state_q;
	logic [31:0]                 count_q;     // live counter
	logic [31:0]                 old_q;       // value carried by the closing beat
	scw_pkg::result_kind_t       kind_q;      // kind of the closing beat
	logic [IDX_W-1:0]            ptr_q;       // slot being examined in the scan
	logic [WAIT_SLOTS-1:0]       free_q;      // one free flag per slot

	logic                        accept;
	logic                        hit;
	logic                        advance;
	logic                        last_slot;
	logic                        any_free;
	logic [IDX_W-1:0]            free_idx;
	logic [IDX_W-1:0]            rd_addr;
	scw_pkg::slot_entry_t        rd_data;
	logic                        wr_en;
	scw_pkg::slot_entry_t        wr_data;
	logic                        load;
	logic                        load_ok;
	scw_pkg::beat_t              beat;
	scw_pkg::beat_t              out_beat;

	// requests are taken only between runs
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	// lowest free slot, priority from slot 0
	always_comb begin
		free_idx = '0;
		any_free = 1'b0;
		for (int i = WAIT_SLOTS - 1; i >= 0; i--) begin
			if (free_q[i]) begin
				free_idx = IDX_W'(i);
				any_free = 1'b1;
			end
		end
	end

	// scan: rd_data holds the entry at ptr_q while in ST_SCAN; a match of an
	// occupied slot against the new count releases it, but only once the
	// output register can take the beat, otherwise the scan holds
	assign last_slot = (ptr_q == IDX_W'(WAIT_SLOTS - 1));
	assign hit       = (state_q == ST_SCAN) && !free_q[ptr_q] && (rd_data.target == count_q);
	assign advance   = (state_q == ST_SCAN) && (!hit || load_ok);

	// read address runs one slot ahead when the scan steps on; idle keeps it at slot 0
	assign rd_addr = (advance && !last_slot) ? ptr_q + IDX_W'(1) : ptr_q;

	// new waiter goes into the slot memory when it neither fails nor is ready now
	assign wr_en   = accept && (scw_pkg::req_type_t'(req_type) == scw_pkg::REQ_WAIT)
	                 && any_free && (target_value != count_q);
	assign wr_data = '{fiber: fiber_id, target: target_value};

	scw_slot_mem #(
		.WAIT_SLOTS (WAIT_SLOTS)
	) u_slot_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (free_idx),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// result beat: a release during the scan, or the closing beat
	always_comb begin
		load = 1'b0;
		beat = '{kind: kind_q, value: old_q, fiber: '0, last: 1'b1};
		if (hit && load_ok) begin
			load = 1'b1;
			beat = '{kind: scw_pkg::KIND_RELEASED, value: count_q,
			         fiber: rd_data.fiber, last: 1'b0};
		end else if ((state_q == ST_ACK) && load_ok) begin
			load = 1'b1;
		end
	end

	scw_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.beat      (beat),
		.load_ok   (load_ok),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_beat  (out_beat)
	);

	assign result_kind    = out_beat.kind;
	assign count_value    = out_beat.value;
	assign released_fiber = out_beat.fiber;
	assign last_of_run    = out_beat.last;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ptr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					ptr_q <= '0;
					if (accept) begin
						if (scw_pkg::req_type_t'(req_type) == scw_pkg::REQ_INC ||
						    scw_pkg::req_type_t'(req_type) == scw_pkg::REQ_DEC) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_ACK;
						end
					end
				end
				ST_SCAN: begin
					if (advance) begin
						if (last_slot) begin
							ptr_q   <= '0;
							state_q <= ST_ACK;
						end else begin
							ptr_q <= ptr_q + IDX_W'(1);
						end
					end
				end
				ST_ACK: begin
					if (load_ok) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// counter and slot flags; a configuration write re-initialises both
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			free_q  <= '1;
		end else if (cfg_wr_en) begin
			count_q <= cfg_wr_data;
			free_q  <= '1;
		end else begin
			if (accept) begin
				case (scw_pkg::req_type_t'(req_type))
					scw_pkg::REQ_INC: count_q <= count_q + amount;
					scw_pkg::REQ_DEC: count_q <= count_q - amount;
					default: ;
				endcase
			end
			if (wr_en) begin
				free_q[free_idx] <= 1'b0;
			end
			if (hit && load_ok) begin
				free_q[ptr_q] <= 1'b1;
			end
		end
	end

	// closing beat contents, latched at accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= scw_pkg::KIND_OLD;
			old_q  <= '0;
		end else if (accept) begin
			old_q <= count_q;
			case (scw_pkg::req_type_t'(req_type))
				scw_pkg::REQ_INC,
				scw_pkg::REQ_DEC:  kind_q <= scw_pkg::KIND_OLD;
				scw_pkg::REQ_WAIT: begin
					if (!any_free) begin
						kind_q <= scw_pkg::KIND_FULL;
					end else if (target_value == count_q) begin
						kind_q <= scw_pkg::KIND_READY;
					end else begin
						kind_q <= scw_pkg::KIND_WAITING;
					end
				end
				default:           kind_q <= scw_pkg::KIND_READ;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/scw_slot_mem.sv]
`default_nettype none
module scw_slot_mem #(
	parameter int unsigned WAIT_SLOTS = scw_pkg::WAIT_SLOTS_DEF,
	localparam int unsigned IDX_W = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1
) (
	input  wire logic                clk,
	input  wire logic                wr_en,
	input  wire logic [IDX_W-1:0]    wr_addr,
	input  wire scw_pkg::slot_entry_t wr_data,
	input  wire logic [IDX_W-1:0]    rd_addr,
	output scw_pkg::slot_entry_t     rd_data
);

	scw_pkg::slot_entry_t mem [WAIT_SLOTS];
	scw_pkg::slot_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

[rtl/scw_out_reg.sv]
`default_nettype none
module scw_out_reg (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    load,
	input  wire scw_pkg::beat_t beat,
	output logic         load_ok,
	output logic         out_valid,
	input  wire logic    out_stall,
	output scw_pkg::beat_t out_beat
);

	logic           valid_q;
	scw_pkg::beat_t beat_q;

	// free, or the held beat leaves this edge
	assign load_ok = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			beat_q <= beat;
		end
	end

	assign out_valid = valid_q;
	assign out_beat  = beat_q;

endmodule
`default_nettype wire
